@@ hw/rtl/psfr_pkg.sv @@
// ----------------------------------------------------------------------------
// psfr_pkg
// Shared types, codes and helper functions of the particle sensor frame
// receiver.
// ----------------------------------------------------------------------------
package psfr_pkg;

  // Item operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Frame status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SUM_ERR = 2'd1;
  localparam logic [1:0] STATUS_CMD_ERR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_COMMAND  = 2'd1;
  localparam logic [1:0] CFG_FINE_LIM = 2'd2;
  localparam logic [1:0] CFG_COARSE_LIM = 2'd3;

  localparam logic [3:0]  FRAME_LAST  = 4'd8;
  localparam logic [13:0] MAX_DECIMAL = 14'd9999;

  // One complete frame, as handed from the front to the back.
  typedef struct packed {
    logic [10:0] sum;
    logic [7:0]  command;
    logic [15:0] coarse_word;
    logic [15:0] fine_word;
    logic [15:0] check_word;
  } frame_t;

  typedef struct packed {
    logic [3:0]  timeout_ticks;
    logic [7:0]  expected_command;
    logic [13:0] fine_limit;
    logic [13:0] coarse_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rest;
  } split_t;

  // Saturate a 16-bit reading to a limit that itself never exceeds four digits.
  function automatic logic [13:0] clamp_value(input logic [15:0] v,
                                              input logic [13:0] limit);
    logic [13:0] lim;
    lim = (limit > MAX_DECIMAL) ? MAX_DECIMAL : limit;
    return (v > {2'b00, lim}) ? lim : v[13:0];
  endfunction

  // Take off one decimal digit by parallel compares against its multiples.
  function automatic split_t split_digit(input logic [13:0] v,
                                         input logic [13:0] unit);
    split_t r;
    r.digit = '0;
    r.rest  = v;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 14'(k * unit)) begin
        r.digit = 4'(k);
        r.rest  = v - 14'(k * unit);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/particle_sensor_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// particle_sensor_frame_receiver
// Assembles and checks nine-byte particle sensor frames from a serial byte
// stream and timer ticks, and reports the PM2.5 and PM10 readings.
// ----------------------------------------------------------------------------
// The input channel carries one item per handshake: either a received serial
// byte or a timer tick. Every ninth byte completes a frame, and only that item
// produces a result item on the output channel, carrying the frame status, the
// two saturated readings and their four-digit packed BCD forms.
// The block accepts one item every cycle while the frame queue is not full. A
// frame-completing item is written into the frame queue and then passes
// through the check, thousands-digit, hundreds-digit and output stages of the
// pipeline, whose last stage is the output register.
// When the receiver stalls, finished frames wait in the pipeline and in the
// frame queue; the input keeps accepting bytes and ticks until the queue is
// full, and only then is in_ready dropped.
// Reset (synchronous, active low) restarts the frame position, idle count and
// running sum, empties the queue and pipeline, and loads the configuration
// registers with their defaults: timeout 2 ticks, command 0x02, PM2.5 limit
// 999 and PM10 limit 1500. The user writes configuration through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module particle_sensor_frame_receiver #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_received_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_status,
  output logic [13:0] out_fine_value,
  output logic [13:0] out_coarse_value,
  output logic [15:0] out_fine_decimal,
  output logic [15:0] out_coarse_decimal
);
  import psfr_pkg::*;

  cfg_t   cfg_r;
  logic   q_full;
  logic   push;
  frame_t push_frame;
  logic   pop;
  logic   pop_valid;
  frame_t pop_frame;

  // Configuration registers. A limit above 9999 is accepted as written; the
  // saturation logic treats it as 9999.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks    <= 4'd2;
      cfg_r.expected_command <= 8'h02;
      cfg_r.fine_limit       <= 14'd999;
      cfg_r.coarse_limit     <= 14'd1500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT:    cfg_r.timeout_ticks    <= cfg_data[3:0];
        CFG_COMMAND:    cfg_r.expected_command <= cfg_data[7:0];
        CFG_FINE_LIM:   cfg_r.fine_limit       <= cfg_data;
        CFG_COARSE_LIM: cfg_r.coarse_limit     <= cfg_data;
        default:        cfg_r                  <= cfg_r;
      endcase
    end
  end

  // The front tracks position, idle time and the running checksum, and hands
  // each completed frame to the queue.
  psfr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_received_byte (in_received_byte),
    .cfg_timeout      (cfg_r.timeout_ticks),
    .q_full           (q_full),
    .push             (push),
    .push_frame       (push_frame)
  );

  psfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_frame  (pop_frame)
  );

  // The back checks the frame, saturates the readings and converts them to
  // packed BCD, then holds the result in its output register.
  psfr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .pop_valid          (pop_valid),
    .pop_frame          (pop_frame),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_status   (out_frame_status),
    .out_fine_value     (out_fine_value),
    .out_coarse_value   (out_coarse_value),
    .out_fine_decimal   (out_fine_decimal),
    .out_coarse_decimal (out_coarse_decimal)
  );

endmodule

@@ hw/rtl/psfr_front.sv @@
// ----------------------------------------------------------------------------
// psfr_front
// Accepts bytes and ticks, tracks the frame position, idle timeout and
// running sum, and pushes each completed frame into the queue.
// ----------------------------------------------------------------------------
module psfr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_operation,
  input  logic [7:0]       in_received_byte,
  input  logic [3:0]       cfg_timeout,
  input  logic             q_full,
  output logic             push,
  output psfr_pkg::frame_t push_frame
);
  import psfr_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic [3:0]  idle_r, idle_nxt;
  logic [10:0] sum_r, sum_nxt;
  logic [7:0]  store_r [1:7];

  logic        accept;
  logic [10:0] sum_base;
  logic [7:0]  addend;
  logic [10:0] sum_new;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign sum_base = (pos_r == '0) ? '0 : sum_r;
  assign addend   = (pos_r <= 4'd5 || pos_r == FRAME_LAST) ? in_received_byte : '0;
  assign sum_new  = sum_base + {3'b000, addend};

  assign push_frame.sum         = sum_new;
  assign push_frame.command     = store_r[1];
  assign push_frame.coarse_word = {store_r[2], store_r[3]};
  assign push_frame.fine_word   = {store_r[4], store_r[5]};
  assign push_frame.check_word  = {store_r[6], store_r[7]};

  always_comb begin
    pos_nxt  = pos_r;
    idle_nxt = idle_r;
    sum_nxt  = sum_r;
    push     = 1'b0;
    if (accept) begin
      if (in_operation == OP_TICK) begin
        if (idle_r >= cfg_timeout) begin
          pos_nxt  = '0;
          idle_nxt = '0;
          sum_nxt  = '0;
        end else begin
          idle_nxt = idle_r + 4'd1;
        end
      end else begin
        idle_nxt = '0;
        if (pos_r == FRAME_LAST) begin
          push    = 1'b1;
          pos_nxt = '0;
          sum_nxt = '0;
        end else begin
          pos_nxt = pos_r + 4'd1;
          sum_nxt = sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      idle_r <= '0;
      sum_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      idle_r <= idle_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Bytes 0 and 8 only feed the sum, so only slots 1 to 7 are kept.
  always_ff @(posedge clk) begin
    if (accept && in_operation == OP_BYTE) begin
      for (int i = 1; i <= 7; i++) begin
        if (pos_r == 4'(i)) begin
          store_r[i] <= in_received_byte;
        end
      end
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= FRAME_LAST)
    else $error("frame position ran past the last byte");

  a_push_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (pos_r == '0 && sum_r == '0))
    else $error("frame did not restart after completion");

  a_timeout_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_TICK && idle_r >= cfg_timeout)
      |=> (pos_r == '0 && idle_r == '0))
    else $error("timeout did not drop the partial frame");

  a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_BYTE) |=> idle_r == '0)
    else $error("idle count not cleared by a byte");

endmodule

@@ hw/rtl/psfr_queue.sv @@
// ----------------------------------------------------------------------------
// psfr_queue
// Small first-in first-out queue of completed frames between front and back.
// ----------------------------------------------------------------------------
module psfr_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  psfr_pkg::frame_t push_frame,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output psfr_pkg::frame_t pop_frame
);
  import psfr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_t          mem_r [DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_frame = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/psfr_back.sv @@
// ----------------------------------------------------------------------------
// psfr_back
// Checks each frame, saturates the readings and splits them into packed BCD
// over a four-stage pipeline whose last stage is the output register.
// ----------------------------------------------------------------------------
module psfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  psfr_pkg::cfg_t   cfg,
  input  logic             pop_valid,
  input  psfr_pkg::frame_t pop_frame,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_frame_status,
  output logic [13:0]      out_fine_value,
  output logic [13:0]      out_coarse_value,
  output logic [15:0]      out_fine_decimal,
  output logic [15:0]      out_coarse_decimal
);
  import psfr_pkg::*;

  // Stage 0: check and saturate.
  logic        v0_r;
  logic [1:0]  st0_r;
  logic [13:0] fv0_r, cv0_r;
  // Stage 1: thousands digit.
  logic        v1_r;
  logic [1:0]  st1_r;
  logic [13:0] fv1_r, cv1_r;
  logic [3:0]  fth1_r, cth1_r;
  logic [9:0]  frest1_r, crest1_r;
  // Stage 2: hundreds digit.
  logic        v2_r;
  logic [1:0]  st2_r;
  logic [13:0] fv2_r, cv2_r;
  logic [3:0]  fth2_r, cth2_r, fhu2_r, chu2_r;
  logic [6:0]  frest2_r, crest2_r;
  // Stage 3: output register.
  logic        v3_r;
  logic [1:0]  st3_r;
  logic [13:0] fv3_r, cv3_r;
  logic [15:0] fdec3_r, cdec3_r;

  logic        adv0, adv1, adv2, adv3;
  logic [1:0]  st_calc;
  logic [13:0] fv_calc, cv_calc;
  split_t      fsp1, csp1, fsp2, csp2, fsp3, csp3;

  assign adv3 = !v3_r || out_ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;
  assign pop  = pop_valid && adv0;

  // The checksum is tested first, so a frame failing both reports a sum error.
  always_comb begin
    st_calc = STATUS_OK;
    fv_calc = '0;
    cv_calc = '0;
    if ({5'b00000, pop_frame.sum} != pop_frame.check_word) begin
      st_calc = STATUS_SUM_ERR;
    end else if (pop_frame.command != cfg.expected_command) begin
      st_calc = STATUS_CMD_ERR;
    end else begin
      fv_calc = clamp_value(pop_frame.fine_word, cfg.fine_limit);
      cv_calc = clamp_value(pop_frame.coarse_word, cfg.coarse_limit);
    end
  end

  assign fsp1 = split_digit(fv0_r, 14'd1000);
  assign csp1 = split_digit(cv0_r, 14'd1000);
  assign fsp2 = split_digit({4'b0000, frest1_r}, 14'd100);
  assign csp2 = split_digit({4'b0000, crest1_r}, 14'd100);
  assign fsp3 = split_digit({7'b0000000, frest2_r}, 14'd10);
  assign csp3 = split_digit({7'b0000000, crest2_r}, 14'd10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv0) v0_r <= pop_valid;
      if (adv1) v1_r <= v0_r;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      st0_r <= st_calc;
      fv0_r <= fv_calc;
      cv0_r <= cv_calc;
    end
    if (adv1) begin
      st1_r    <= st0_r;
      fv1_r    <= fv0_r;
      cv1_r    <= cv0_r;
      fth1_r   <= fsp1.digit;
      cth1_r   <= csp1.digit;
      frest1_r <= fsp1.rest[9:0];
      crest1_r <= csp1.rest[9:0];
    end
    if (adv2) begin
      st2_r    <= st1_r;
      fv2_r    <= fv1_r;
      cv2_r    <= cv1_r;
      fth2_r   <= fth1_r;
      cth2_r   <= cth1_r;
      fhu2_r   <= fsp2.digit;
      chu2_r   <= csp2.digit;
      frest2_r <= fsp2.rest[6:0];
      crest2_r <= csp2.rest[6:0];
    end
    if (adv3) begin
      st3_r   <= st2_r;
      fv3_r   <= fv2_r;
      cv3_r   <= cv2_r;
      fdec3_r <= {fth2_r, fhu2_r, fsp3.digit, fsp3.rest[3:0]};
      cdec3_r <= {cth2_r, chu2_r, csp3.digit, csp3.rest[3:0]};
    end
  end

  assign out_valid          = v3_r;
  assign out_frame_status   = st3_r;
  assign out_fine_value     = fv3_r;
  assign out_coarse_value   = cv3_r;
  assign out_fine_decimal   = fdec3_r;
  assign out_coarse_decimal = cdec3_r;

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_status != STATUS_OK)
      |-> (out_fine_value == '0 && out_coarse_value == '0 &&
           out_fine_decimal == '0 && out_coarse_decimal == '0))
    else $error("failed frame carries nonzero readings");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_status == STATUS_OK ||
                   out_frame_status == STATUS_SUM_ERR ||
                   out_frame_status == STATUS_CMD_ERR))
    else $error("unknown frame status");

  a_four_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fine_value <= MAX_DECIMAL && out_coarse_value <= MAX_DECIMAL))
    else $error("reading exceeds four decimal digits");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fine_decimal[15:12] <= 4'd9 && out_fine_decimal[11:8] <= 4'd9 &&
                   out_fine_decimal[7:4] <= 4'd9 && out_fine_decimal[3:0] <= 4'd9 &&
                   out_coarse_decimal[15:12] <= 4'd9 &&
                   out_coarse_decimal[11:8] <= 4'd9 &&
                   out_coarse_decimal[7:4] <= 4'd9 && out_coarse_decimal[3:0] <= 4'd9))
    else $error("packed BCD digit above nine");

endmodule
